/* src/blz_pkg.sv */
// Shared types and constants for the backward LZ decompressor.
package blz_pkg;

  localparam int unsigned HISTORY_DEPTH_DEF = 8192;

  localparam int unsigned LEN_W    = 5;    // copy length 3..18
  localparam int unsigned DIST_W   = 13;   // copy distance 3..4098
  localparam int unsigned LEN_BIAS  = 3;
  localparam int unsigned DIST_BIAS = 3;
  localparam int unsigned MAX_LEN   = 18;
  localparam int unsigned FLAGS_PER_BYTE = 8;

  typedef enum logic [1:0] {
    CMD_LIT   = 2'd0,
    CMD_COPY  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [7:0]        data;
    logic [LEN_W-1:0]  len;
    logic [DIST_W-1:0] distance;
    logic              last;
  } cmd_t;

endpackage

/* src/backward_lz_decompressor.sv */
// Top level of the backward LZ decompressor: token parser and copy engine.
//
// Compressed bytes enter one per transfer, flag byte first, flags read MSB
// first: a clear flag passes the next byte through as a literal, a set flag
// takes a two-byte token (length = high nibble + 3, distance = low 12 bits
// + 3) and replays that many bytes from the produced history, one at a time,
// so overlapping copies work. Results leave one byte per transfer through an
// output register. A flag byte or a token high byte makes no result. A token
// low byte starts a copy that holds in_ready low while its bytes are read one
// at a time through the history memory's single read port, which has a
// registered read, and for longer if the output side stalls. in_ready is
// also low while a finished result waits with out_ready low. A copy reaching
// before the first byte of the stream yields a 0 byte with out_bad_reference
// set. in_last_in ends the stream: the final result it causes carries
// out_last, and the parser and produced count return to their reset state;
// a last byte that causes no result still ends the stream. No clearing pass
// runs after reset.
module backward_lz_decompressor #(
  parameter int unsigned HISTORY_DEPTH = blz_pkg::HISTORY_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_bad_reference,
  output logic       out_last
);

  // parser phases: flag byte, literal or token high byte, token low byte
  typedef enum logic [1:0] {PH_FLAG, PH_ITEM, PH_LOW} phase_t;

  phase_t        phase_r, phase_nxt;
  logic [7:0]    flag_bits_r, flag_bits_nxt;
  logic [3:0]    flags_left_r, flags_left_nxt;
  logic [7:0]    token_high_r, token_high_nxt;

  logic          in_go;
  logic          cmd_valid, cmd_ready;
  blz_pkg::cmd_t cmd;

  // the engine owns the history; one command per accepted byte at most
  blz_copy_engine #(
    .HISTORY_DEPTH (HISTORY_DEPTH)
  ) u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd_valid         (cmd_valid),
    .cmd               (cmd),
    .cmd_ready         (cmd_ready),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_byte          (out_byte),
    .out_bad_reference (out_bad_reference),
    .out_last          (out_last)
  );

  // accept only when the engine is idle with a free output slot, so every
  // command issued below is taken in the same cycle
  assign in_ready = cmd_ready;
  assign in_go    = in_valid && in_ready;

  always_comb begin
    phase_nxt      = phase_r;
    flag_bits_nxt  = flag_bits_r;
    flags_left_nxt = flags_left_r;
    token_high_nxt = token_high_r;
    cmd_valid      = 1'b0;
    cmd.kind       = blz_pkg::CMD_CLEAR;
    cmd.data       = in_data_byte;
    cmd.len        = blz_pkg::LEN_W'(token_high_r[7:4]) + blz_pkg::LEN_W'(blz_pkg::LEN_BIAS);
    cmd.distance   = blz_pkg::DIST_W'({token_high_r[3:0], in_data_byte})
                     + blz_pkg::DIST_W'(blz_pkg::DIST_BIAS);
    cmd.last       = in_last_in;

    if (in_go) begin
      unique case (phase_r)
        PH_FLAG: begin
          // load a new flag byte
          flag_bits_nxt  = in_data_byte;
          flags_left_nxt = 4'(blz_pkg::FLAGS_PER_BYTE);
          phase_nxt      = PH_ITEM;
          cmd_valid      = in_last_in;
        end
        PH_ITEM: begin
          if (flag_bits_r[7]) begin
            // hold the token high byte until the low byte arrives
            token_high_nxt = in_data_byte;
            phase_nxt      = PH_LOW;
            cmd_valid      = in_last_in;
          end else begin
            cmd_valid      = 1'b1;
            cmd.kind       = blz_pkg::CMD_LIT;
            flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
            flags_left_nxt = flags_left_r - 4'd1;
            phase_nxt      = (flags_left_r == 4'd1) ? PH_FLAG : PH_ITEM;
          end
        end
        PH_LOW: begin
          cmd_valid      = 1'b1;
          cmd.kind       = blz_pkg::CMD_COPY;
          flag_bits_nxt  = {flag_bits_r[6:0], 1'b0};
          flags_left_nxt = flags_left_r - 4'd1;
          phase_nxt      = (flags_left_r == 4'd1) ? PH_FLAG : PH_ITEM;
        end
        default: begin
          phase_nxt = PH_FLAG;
        end
      endcase

      // end of stream: drop parser state
      if (in_last_in) begin
        phase_nxt      = PH_FLAG;
        flag_bits_nxt  = '0;
        flags_left_nxt = '0;
        token_high_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_FLAG;
      flag_bits_r  <= '0;
      flags_left_r <= '0;
      token_high_r <= '0;
    end else begin
      phase_r      <= phase_nxt;
      flag_bits_r  <= flag_bits_nxt;
      flags_left_r <= flags_left_nxt;
      token_high_r <= token_high_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_cmd_taken: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_valid |-> cmd_ready)
    else $error("command issued while engine busy");

  a_item_has_flags: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r != PH_FLAG |-> flags_left_r != 4'd0)
    else $error("item phase with no flags left");

  a_no_out_on_flag: assert property (@(posedge clk) disable iff (!rst_n)
    in_go && phase_r == PH_FLAG && !in_last_in |=> !(out_valid && !$past(out_valid)))
    else $error("flag byte produced a result");
`endif

endmodule

/* src/blz_ram.sv */
// Generic simple dual-port RAM with registered read that holds when not enabled.
module blz_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = blz_pkg::HISTORY_DEPTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/blz_copy_engine.sv */
// History memory, shared address unit and copy sequencer with output register.
module blz_copy_engine #(
  parameter int unsigned HISTORY_DEPTH = blz_pkg::HISTORY_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  blz_pkg::cmd_t cmd,
  output logic          cmd_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_bad_reference,
  output logic          out_last
);

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t                     state_r, state_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [7:0]                 out_byte_r, out_byte_nxt;
  logic                       out_bad_r, out_bad_nxt;
  logic                       out_last_r, out_last_nxt;
  logic                       pend_r, pend_nxt;
  logic                       pend_bad_r, pend_bad_nxt;
  logic                       pend_last_r, pend_last_nxt;
  logic [blz_pkg::LEN_W-1:0]  len_left_r, len_left_nxt;
  logic [blz_pkg::DIST_W-1:0] dist_r, dist_nxt;
  logic                       last_r, last_nxt;
  logic [AW-1:0]              src_r, src_nxt;
  logic [CW-1:0]              iss_cnt_r, iss_cnt_nxt;
  logic [CW-1:0]              prod_cnt_r, prod_cnt_nxt;
  logic [AW-1:0]              wp_r, wp_nxt;

  logic          out_free, cmd_go, lit_go, load, issue, emit;
  logic [7:0]    emit_byte, rdata;
  logic [AW-1:0] addr_base, wp_inc;
  logic [AW:0]   addr_step, addr_sum, addr_wrap;
  logic [CW-1:0] prod_inc, iss_inc;

  blz_ram #(
    .WIDTH (8),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (emit),
    .waddr (wp_r),
    .wdata (emit_byte),
    .re    (issue),
    .raddr (src_r),
    .rdata (rdata)
  );

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    cmd_ready = (state_r == ST_IDLE) && out_free;
    cmd_go    = cmd_valid && cmd_ready;
    lit_go    = cmd_go && (cmd.kind == blz_pkg::CMD_LIT);
    load      = (state_r == ST_RUN) && pend_r && out_free;
    issue     = (state_r == ST_RUN) && (len_left_r != '0) && (!pend_r || load);
    emit      = lit_go || load;
    emit_byte = lit_go ? cmd.data : (pend_bad_r ? 8'd0 : rdata);

    // shared modular address adder: start point when idle, step when running
    addr_base = (state_r == ST_RUN) ? src_r : wp_r;
    addr_step = (state_r == ST_RUN) ? (AW+1)'(1)
                : (AW+1)'(HISTORY_DEPTH) - (AW+1)'(cmd.distance);
    addr_sum  = {1'b0, addr_base} + addr_step;
    addr_wrap = (addr_sum >= (AW+1)'(HISTORY_DEPTH))
                ? addr_sum - (AW+1)'(HISTORY_DEPTH) : addr_sum;

    wp_inc   = (wp_r == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_r + AW'(1);
    prod_inc = (prod_cnt_r == CW'(HISTORY_DEPTH)) ? prod_cnt_r : prod_cnt_r + CW'(1);
    iss_inc  = (iss_cnt_r == CW'(HISTORY_DEPTH)) ? iss_cnt_r : iss_cnt_r + CW'(1);
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_bad_nxt   = out_bad_r;
    out_last_nxt  = out_last_r;
    pend_nxt      = pend_r;
    pend_bad_nxt  = pend_bad_r;
    pend_last_nxt = pend_last_r;
    len_left_nxt  = len_left_r;
    dist_nxt      = dist_r;
    last_nxt      = last_r;
    src_nxt       = src_r;
    iss_cnt_nxt   = iss_cnt_r;
    prod_cnt_nxt  = prod_cnt_r;
    wp_nxt        = wp_r;

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_bad_nxt   = lit_go ? 1'b0 : pend_bad_r;
      out_last_nxt  = lit_go ? cmd.last : pend_last_r;
      wp_nxt        = wp_inc;
      prod_cnt_nxt  = prod_inc;
    end

    if (cmd_go) begin
      unique case (cmd.kind)
        blz_pkg::CMD_LIT: begin
          if (cmd.last) begin
            prod_cnt_nxt = '0;
          end
        end
        blz_pkg::CMD_CLEAR: begin
          prod_cnt_nxt = '0;
        end
        blz_pkg::CMD_COPY: begin
          state_nxt    = ST_RUN;
          len_left_nxt = cmd.len;
          dist_nxt     = cmd.distance;
          last_nxt     = cmd.last;
          iss_cnt_nxt  = prod_cnt_r;
          src_nxt      = addr_wrap[AW-1:0];
          pend_nxt     = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (issue) begin
      pend_nxt      = 1'b1;
      pend_bad_nxt  = CW'(dist_r) > iss_cnt_r;
      pend_last_nxt = last_r && (len_left_r == blz_pkg::LEN_W'(1));
      src_nxt       = addr_wrap[AW-1:0];
      iss_cnt_nxt   = iss_inc;
      len_left_nxt  = len_left_r - blz_pkg::LEN_W'(1);
    end else if (load) begin
      pend_nxt = 1'b0;
    end

    if (load && (len_left_r == '0)) begin
      state_nxt = ST_IDLE;
      if (last_r) begin
        prod_cnt_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
      len_left_r  <= '0;
      prod_cnt_r  <= '0;
      iss_cnt_r   <= '0;
      wp_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
      len_left_r  <= len_left_nxt;
      prod_cnt_r  <= prod_cnt_nxt;
      iss_cnt_r   <= iss_cnt_nxt;
      wp_r        <= wp_nxt;
    end
    out_byte_r  <= out_byte_nxt;
    out_bad_r   <= out_bad_nxt;
    out_last_r  <= out_last_nxt;
    pend_bad_r  <= pend_bad_nxt;
    pend_last_r <= pend_last_nxt;
    dist_r      <= dist_nxt;
    last_r      <= last_nxt;
    src_r       <= src_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_byte          = out_byte_r;
  assign out_bad_reference = out_bad_r;
  assign out_last          = out_last_r;

`ifndef NO_ASSERTIONS
  a_bad_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_bad_r |-> out_byte_r == 8'd0)
    else $error("bad reference result carries nonzero byte");

  a_pend_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_RUN)
    else $error("pending read outside copy");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    prod_cnt_r <= CW'(HISTORY_DEPTH))
    else $error("produced count above history depth");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_left_r <= blz_pkg::LEN_W'(blz_pkg::MAX_LEN))
    else $error("copy length out of range");

  a_idle_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN && load && len_left_r == '0 |=> state_r == ST_IDLE && !pend_r)
    else $error("copy did not finish after last byte");
`endif

endmodule
